// ----- rtl/trm_pkg.sv -----
// ============================================================================
// trm_pkg
// Shared types and constants for the tetra refinement marker.
// ============================================================================
`default_nettype none

package trm_pkg;

    localparam int unsigned QDEPTH       = 4;
    localparam int unsigned QPTR_W       = 2;
    localparam int unsigned QCNT_W       = 3;
    localparam logic [3:0]  SIGN_SAMPLES = 4'd10;
    localparam logic [3:0]  COUNT_SAT    = 4'd15;

    typedef enum logic [2:0] {
        CFG_SHELL_WIDTH       = 3'd0,
        CFG_CURVATURE_SCALE   = 3'd1,
        CFG_INITIAL_MESH_SIZE = 3'd2,
        CFG_FINE_LEVEL_MIN    = 3'd3,
        CFG_FINE_LEVEL_MAX    = 3'd4,
        CFG_COARSE_LEVEL      = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MARK_KEEP   = 2'd0,
        MARK_REFINE = 2'd1,
        MARK_REMOVE = 2'd2
    } t_mark;

    typedef struct packed {
        logic [30:0] shell_width;
        logic [30:0] curvature_scale;
        logic [30:0] initial_mesh_size;
        logic [3:0]  fine_level_min;
        logic [3:0]  fine_level_max;
        logic [3:0]  coarse_level;
    } t_cfg;

    typedef struct packed {
        logic [30:0] min_abs_dist;
        logic [30:0] max_abs_curv;
        logic        sign_change;
        logic [3:0]  tetra_level;
        logic        is_regular;
    } t_tetra_rec;

    function automatic logic [30:0] abs_sat(input logic [31:0] v);
        logic [31:0] neg;
        neg = ~v + 32'd1;
        if (v == 32'h8000_0000) begin
            return 31'h7FFF_FFFF;
        end else if (v[31]) begin
            return neg[30:0];
        end else begin
            return v[30:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/trm_front.sv -----
// ============================================================================
// trm_front
// Accumulates the samples of one tetra and emits a record on its barycenter.
// ============================================================================
`default_nettype none

module trm_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic signed [31:0]  i_dist_req,
    input  wire logic signed [31:0]  i_curvature,
    input  wire logic                i_center_last,
    input  wire logic [3:0]          i_tetra_level,
    input  wire logic                i_is_regular,
    output      logic                o_rec_push,
    output      trm_pkg::t_tetra_rec o_rec
);

    logic [30:0] r_min_abs_dist, n_min_abs_dist;
    logic [30:0] r_max_abs_curv, n_max_abs_curv;
    logic [3:0]  r_nonneg_count;
    logic [30:0] ad;
    logic [30:0] ak;

    always_comb begin
        ad = trm_pkg::abs_sat(i_dist_req);
        ak = trm_pkg::abs_sat(i_curvature);
        n_min_abs_dist = (ad < r_min_abs_dist) ? ad : r_min_abs_dist;
        n_max_abs_curv = (ak > r_max_abs_curv) ? ak : r_max_abs_curv;
    end

    always_comb begin
        o_rec_push           = i_accept && i_center_last;
        o_rec.min_abs_dist   = n_min_abs_dist;
        o_rec.max_abs_curv   = n_max_abs_curv;
        o_rec.sign_change    = (r_nonneg_count != 4'd0) &&
                               (r_nonneg_count != trm_pkg::SIGN_SAMPLES);
        o_rec.tetra_level    = i_tetra_level;
        o_rec.is_regular     = i_is_regular;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_abs_dist <= '1;
            r_max_abs_curv <= '0;
            r_nonneg_count <= '0;
        end else if (i_accept) begin
            if (i_center_last) begin
                r_min_abs_dist <= '1;
                r_max_abs_curv <= '0;
                r_nonneg_count <= '0;
            end else begin
                r_min_abs_dist <= n_min_abs_dist;
                r_max_abs_curv <= n_max_abs_curv;
                if (!i_dist_req[31] && (r_nonneg_count != trm_pkg::COUNT_SAT)) begin
                    r_nonneg_count <= r_nonneg_count + 4'd1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/trm_queue.sv -----
// ============================================================================
// trm_queue
// Short queue of tetra records between the accumulator and the level unit.
// ============================================================================
`default_nettype none

module trm_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire trm_pkg::t_tetra_rec i_data,
    output      logic                o_full,
    input  wire logic                i_pop,
    output      logic                o_empty,
    output      trm_pkg::t_tetra_rec o_data
);

    trm_pkg::t_tetra_rec r_mem [trm_pkg::QDEPTH];
    logic [trm_pkg::QPTR_W-1:0] r_wptr;
    logic [trm_pkg::QPTR_W-1:0] r_rptr;
    logic [trm_pkg::QCNT_W-1:0] r_count;
    logic                       do_push;
    logic                       do_pop;

    always_comb begin
        o_full  = (r_count == trm_pkg::QCNT_W'(trm_pkg::QDEPTH));
        o_empty = (r_count == '0);
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        o_data  = r_mem[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= trm_pkg::QCNT_W'(trm_pkg::QDEPTH))
        else $error("queue count exceeds depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue pushed while full");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not grow on push");

endmodule

`default_nettype wire

// ----- rtl/trm_back.sv -----
// ============================================================================
// trm_back
// Three stage level unit: product, level search, clamp and mark decision.
// ============================================================================
`default_nettype none

module trm_back #(
    parameter int unsigned MAX_LEVEL = 15
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire trm_pkg::t_cfg       i_cfg,
    input  wire logic                i_rec_empty,
    input  wire trm_pkg::t_tetra_rec i_rec,
    output      logic                o_rec_pop,
    output      logic                o_empty,
    input  wire logic                i_pop,
    output      logic [1:0]          o_mark,
    output      logic [3:0]          o_target_level
);

    localparam int unsigned TW = $clog2(MAX_LEVEL + 1);
    localparam int unsigned CW = (TW > 4) ? TW : 4;
    localparam int unsigned LW = (MAX_LEVEL > 15) ? (47 + MAX_LEVEL) : 62;

    logic          r_v1, r_v2, r_v3;
    logic          rdy1, rdy2, rdy3;

    logic [61:0]   r_s1_rhs;
    logic          r_s1_in_shell;
    logic [3:0]    r_s1_level;
    logic          r_s1_regular;

    logic [TW-1:0] r_s2_unc, n_s2_unc;
    logic          r_s2_in_shell;
    logic [3:0]    r_s2_level;
    logic          r_s2_regular;

    trm_pkg::t_mark r_s3_mark, n_s3_mark;
    logic [3:0]    r_s3_target, n_s3_target;

    logic [LW-1:0] base;
    logic [LW-1:0] rhs_ext;
    logic [CW-1:0] t_c;

    always_comb begin
        rdy3      = !r_v3 || i_pop;
        rdy2      = !r_v2 || rdy3;
        rdy1      = !r_v1 || rdy2;
        o_rec_pop = !i_rec_empty && rdy1;
        o_empty   = !r_v3;
        o_mark    = r_s3_mark;
        o_target_level = r_s3_target;
    end

    always_comb begin
        base     = LW'({i_cfg.curvature_scale, 16'b0});
        rhs_ext  = LW'(r_s1_rhs);
        n_s2_unc = TW'(MAX_LEVEL);
        for (int n = MAX_LEVEL - 1; n >= 0; n--) begin
            if ((base << n) >= rhs_ext) begin
                n_s2_unc = TW'(n);
            end
        end
    end

    always_comb begin
        t_c = CW'(r_s2_unc);
        if (t_c < CW'(i_cfg.fine_level_min)) begin
            t_c = CW'(i_cfg.fine_level_min);
        end
        if (t_c > CW'(i_cfg.fine_level_max)) begin
            t_c = CW'(i_cfg.fine_level_max);
        end
        n_s3_target = r_s2_in_shell ? t_c[3:0] : i_cfg.coarse_level;
        if ((r_s2_level != n_s3_target) || !r_s2_regular) begin
            n_s3_mark = (r_s2_level <= n_s3_target) ? trm_pkg::MARK_REFINE
                                                    : trm_pkg::MARK_REMOVE;
        end else begin
            n_s3_mark = trm_pkg::MARK_KEEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_rhs      <= 62'(i_cfg.initial_mesh_size) * 62'(i_rec.max_abs_curv);
            r_s1_in_shell <= (i_rec.min_abs_dist <= i_cfg.shell_width) ||
                             i_rec.sign_change;
            r_s1_level    <= i_rec.tetra_level;
            r_s1_regular  <= i_rec.is_regular;
        end
        if (rdy2) begin
            r_s2_unc      <= n_s2_unc;
            r_s2_in_shell <= r_s1_in_shell;
            r_s2_level    <= r_s1_level;
            r_s2_regular  <= r_s1_regular;
        end
        if (rdy3) begin
            r_s3_mark     <= n_s3_mark;
            r_s3_target   <= n_s3_target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= !i_rec_empty;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    a_keep_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rdy3 && r_v2 && (n_s3_mark == trm_pkg::MARK_KEEP))
            |=> (r_s3_target == $past(r_s2_level)))
        else $error("keep mark with differing level");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_v3 && !i_pop) |=> (r_v2 && $stable(r_s2_unc)))
        else $error("level stage lost data under stall");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !i_pop) |=> (r_v3 && $stable(r_s3_mark) && $stable(r_s3_target)))
        else $error("waiting result changed before it was taken");

endmodule

`default_nettype wire

// ----- rtl/tetra_refinement_marker_unit.sv -----
// ============================================================================
// tetra_refinement_marker_unit
// Marks tetrahedra for refinement or removal from streamed sample data.
// ============================================================================
// Throughput: one sample transaction per cycle while the record queue is not full.
// A result passes through the record queue and the product, level search
// and mark stage registers before it shows on the result side.
// A four-entry record queue lets the sample side run while results wait.
// Reset: synchronous active-low; accumulators, queue and pipeline clear and
// the configuration registers return to their defaults.
`default_nettype none

module tetra_refinement_marker_unit #(
    parameter int unsigned MAX_LEVEL = 15
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output      logic               full,
    input  wire logic signed [31:0] i_dist_req,
    input  wire logic signed [31:0] i_curvature,
    input  wire logic               i_center_last,
    input  wire logic [3:0]         i_tetra_level,
    input  wire logic               i_is_regular,
    output      logic               empty,
    input  wire logic               pop,
    output      logic [1:0]         o_mark,
    output      logic [3:0]         o_target_level,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [30:0]        i_cfg_wdata
);

    trm_pkg::t_cfg       r_cfg;
    trm_pkg::t_tetra_rec front_rec;
    trm_pkg::t_tetra_rec q_rec;
    logic                front_push;
    logic                q_empty;
    logic                q_pop;
    logic                accept;

    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shell_width       <= 31'd0;
            r_cfg.curvature_scale   <= 31'd65536;
            r_cfg.initial_mesh_size <= 31'd65536;
            r_cfg.fine_level_min    <= 4'd0;
            r_cfg.fine_level_max    <= 4'd0;
            r_cfg.coarse_level      <= 4'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                trm_pkg::CFG_SHELL_WIDTH:       r_cfg.shell_width       <= i_cfg_wdata;
                trm_pkg::CFG_CURVATURE_SCALE:   r_cfg.curvature_scale   <= i_cfg_wdata;
                trm_pkg::CFG_INITIAL_MESH_SIZE: r_cfg.initial_mesh_size <= i_cfg_wdata;
                trm_pkg::CFG_FINE_LEVEL_MIN:    r_cfg.fine_level_min    <= i_cfg_wdata[3:0];
                trm_pkg::CFG_FINE_LEVEL_MAX:    r_cfg.fine_level_max    <= i_cfg_wdata[3:0];
                trm_pkg::CFG_COARSE_LEVEL:      r_cfg.coarse_level      <= i_cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    trm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_dist_req    (i_dist_req),
        .i_curvature   (i_curvature),
        .i_center_last (i_center_last),
        .i_tetra_level (i_tetra_level),
        .i_is_regular  (i_is_regular),
        .o_rec_push    (front_push),
        .o_rec         (front_rec)
    );

    trm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_rec),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rec)
    );

    trm_back #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_rec_empty    (q_empty),
        .i_rec          (q_rec),
        .o_rec_pop      (q_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_mark         (o_mark),
        .o_target_level (o_target_level)
    );

endmodule

`default_nettype wire
